// ===== design/connection_keepalive_reconnect_fsm_core_assert.svh =====
// Assertion macros for the link supervisor.
// Taken in by the top level; relies on no other file.
`ifndef CONNECTION_KEEPALIVE_RECONNECT_FSM_CORE_ASSERT_SVH
`define CONNECTION_KEEPALIVE_RECONNECT_FSM_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CKR_ASSERT_IMP(label, clock, rstn, ante, cons) \
	label: assert property (@(posedge clock) disable iff (!(rstn)) (ante) |-> (cons)) \
		else $error("link supervisor check failed");

// The consequent must hold in the cycle after the antecedent.
`define CKR_ASSERT_NEXT(label, clock, rstn, ante, cons) \
	label: assert property (@(posedge clock) disable iff (!(rstn)) (ante) |=> (cons)) \
		else $error("link supervisor check failed");

`endif

// ===== design/ckr_pkg.sv =====
// Types and constants shared by the link supervisor modules.
// Has no dependencies; compiled first.
`timescale 1ns / 1ps

package ckr_pkg;

	typedef enum logic [2:0] {
		MODE_START     = 3'd0,
		MODE_INFO      = 3'd1,
		MODE_PONG      = 3'd2,
		MODE_PING_TICK = 3'd3,
		MODE_CLOSED    = 3'd4,
		MODE_RECONNECT = 3'd5,
		MODE_USER_CLOSE = 3'd6
	} mode_t;

	typedef enum logic [2:0] {
		LS_CLOSED       = 3'd0,
		LS_CONNECTING   = 3'd1,
		LS_CONNECTED    = 3'd2,
		LS_DISCONNECTED = 3'd3,
		LS_RECONNECTING = 3'd4
	} link_state_t;

	typedef enum logic [1:0] {
		NOTE_NONE         = 2'd0,
		NOTE_CONNECTED    = 2'd1,
		NOTE_DISCONNECTED = 2'd2
	} notice_t;

	typedef enum logic [2:0] {
		ERR_NONE           = 3'd0,
		ERR_PING_TIMEOUT   = 3'd1,
		ERR_CONN_LOST      = 3'd2,
		ERR_RECONNECT_LIM  = 3'd3,
		ERR_CONNECT_FAILED = 3'd4
	} err_t;

	localparam int unsigned CfgIdxW  = 2;
	localparam int unsigned CfgDataW = 8;

	localparam logic [CfgIdxW-1:0] CFG_MAX_PINGS     = 2'd0;
	localparam logic [CfgIdxW-1:0] CFG_MAX_RECONNECT = 2'd1;
	localparam logic [CfgIdxW-1:0] CFG_ALLOW_RECONN  = 2'd2;

	localparam logic [7:0] MAX_PINGS_RST     = 8'd2;
	localparam logic [7:0] MAX_RECONNECT_RST = 8'd60;
	localparam logic       ALLOW_RECONN_RST  = 1'b1;

	localparam logic [7:0] PINGS_SAT = 8'hff;
	localparam logic [8:0] TRIES_SAT = 9'h1ff;

	typedef struct packed {
		logic [7:0] max_pings_out;
		logic [7:0] max_reconnect;
		logic       allow_reconnect;
	} ckr_cfg_t;

	typedef struct packed {
		link_state_t link;
		logic [7:0]  pings;
		logic [8:0]  tries;
		logic        timer_on;
		logic        chan_open;
	} ckr_state_t;

	typedef struct packed {
		link_state_t link_state;
		logic        send_ping;
		logic        send_connect;
		logic        close_channel;
		logic        dial_channel;
		logic        reset_parser;
		notice_t     notice;
		err_t        error_code;
	} ckr_result_t;

endpackage

// ===== design/ckr_req_if.sv =====
// Event channel: one word is one event and its dial outcome.
// Depends on nothing.
`timescale 1ns / 1ps

interface ckr_req_if;
	logic       valid;
	logic       ready;
	logic [2:0] mode;
	logic       connect_ok;

	modport source (output valid, output mode, output connect_ok, input ready);
	modport sink (input valid, input mode, input connect_ok, output ready);
endinterface

// ===== design/ckr_rsp_if.sv =====
// Result channel: one word is the link state and strobes after one event.
// Depends on nothing.
`timescale 1ns / 1ps

interface ckr_rsp_if;
	logic       valid;
	logic       ready;
	logic [2:0] link_state;
	logic       send_ping;
	logic       send_connect;
	logic       close_channel;
	logic       dial_channel;
	logic       reset_parser;
	logic [1:0] notice;
	logic [2:0] error_code;

	modport source (output valid, output link_state, output send_ping, output send_connect,
		output close_channel, output dial_channel, output reset_parser, output notice,
		output error_code, input ready);
	modport sink (input valid, input link_state, input send_ping, input send_connect,
		input close_channel, input dial_channel, input reset_parser, input notice,
		input error_code, output ready);
endinterface

// ===== design/ckr_cfg_if.sv =====
// Configuration write channel: a register index and its write data.
// Depends on nothing.
`timescale 1ns / 1ps

interface ckr_cfg_if;
	logic       valid;
	logic       ready;
	logic [1:0] index;
	logic [7:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

// ===== design/connection_keepalive_reconnect_fsm_core.sv =====
// An accepted event is held in the input register; its result is registered in the result
// register as the event leaves, and the result word is offered from there.
// Throughput: one event per cycle; a held result word stalls intake only when the
// input register is also full. The link state registers update as each event leaves
// the input register. Reset (arst_n low) gives link closed, counters and flags cleared,
// configuration at its defaults and both channels empty.
`timescale 1ns / 1ps
`include "connection_keepalive_reconnect_fsm_core_assert.svh"

module connection_keepalive_reconnect_fsm_core (
	input logic    clk,
	input logic    arst_n,
	ckr_req_if.sink   req,
	ckr_rsp_if.source rsp,
	ckr_cfg_if.sink   cfg
);
	import ckr_pkg::*;

	ckr_cfg_t    regs;
	ckr_state_t  state_q;
	ckr_state_t  state_nxt;
	ckr_result_t res_comb;
	ckr_result_t res_s2;
	logic        valid_s1;
	logic [2:0]  mode_s1;
	logic        ok_s1;
	logic        valid_s2;
	logic        adv;

	ckr_cfg_regs u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.regs   (regs)
	);

	ckr_step u_step (
		.mode       (mode_s1),
		.connect_ok (ok_s1),
		.regs       (regs),
		.cur        (state_q),
		.nxt        (state_nxt),
		.res        (res_comb)
	);

	assign adv       = valid_s1 && (!valid_s2 || rsp.ready);
	assign req.ready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.ready) begin
			valid_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req.ready && req.valid) begin
			mode_s1 <= req.mode;
			ok_s1   <= req.connect_ok;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.link      <= LS_CLOSED;
			state_q.pings     <= '0;
			state_q.tries     <= '0;
			state_q.timer_on  <= 1'b0;
			state_q.chan_open <= 1'b0;
		end else if (adv) begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= 1'b1;
		end else if (rsp.ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_s2 <= res_comb;
		end
	end

	assign rsp.valid         = valid_s2;
	assign rsp.link_state    = res_s2.link_state;
	assign rsp.send_ping     = res_s2.send_ping;
	assign rsp.send_connect  = res_s2.send_connect;
	assign rsp.close_channel = res_s2.close_channel;
	assign rsp.dial_channel  = res_s2.dial_channel;
	assign rsp.reset_parser  = res_s2.reset_parser;
	assign rsp.notice        = res_s2.notice;
	assign rsp.error_code    = res_s2.error_code;

	`CKR_ASSERT_IMP(a_closed_no_chan, clk, arst_n, state_q.link == LS_CLOSED, !state_q.chan_open)
	`CKR_ASSERT_IMP(a_stall_cause, clk, arst_n, !req.ready, valid_s1 && valid_s2 && !rsp.ready)
	`CKR_ASSERT_NEXT(a_user_close, clk, arst_n, adv && (mode_s1 == MODE_USER_CLOSE),
		state_q.link == LS_CLOSED && !state_q.timer_on)
endmodule

// ===== design/ckr_cfg_regs.sv =====
// Configuration registers of the link supervisor.
// Depends on ckr_pkg and ckr_cfg_if.
`timescale 1ns / 1ps

module ckr_cfg_regs (
	input  logic             clk,
	input  logic             arst_n,
	ckr_cfg_if.sink          cfg,
	output ckr_pkg::ckr_cfg_t regs
);
	import ckr_pkg::*;

	ckr_cfg_t regs_q;

	assign cfg.ready = 1'b1;
	assign regs = regs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.max_pings_out   <= MAX_PINGS_RST;
			regs_q.max_reconnect   <= MAX_RECONNECT_RST;
			regs_q.allow_reconnect <= ALLOW_RECONN_RST;
		end else if (cfg.valid) begin
			case (cfg.index)
				CFG_MAX_PINGS:     regs_q.max_pings_out   <= cfg.data;
				CFG_MAX_RECONNECT: regs_q.max_reconnect   <= cfg.data;
				CFG_ALLOW_RECONN:  regs_q.allow_reconnect <= cfg.data[0];
				default: ;
			endcase
		end
	end
endmodule

// ===== design/ckr_step.sv =====
// Next-state and result logic for one event of the link supervisor.
// Purely combinational; depends on ckr_pkg.
`timescale 1ns / 1ps

module ckr_step (
	input  logic                 [2:0] mode,
	input  logic                       connect_ok,
	input  ckr_pkg::ckr_cfg_t          regs,
	input  ckr_pkg::ckr_state_t        cur,
	output ckr_pkg::ckr_state_t        nxt,
	output ckr_pkg::ckr_result_t       res
);
	import ckr_pkg::*;

	logic [8:0] tries_inc;
	logic [7:0] pings_inc;

	assign tries_inc = (cur.tries == TRIES_SAT) ? cur.tries : cur.tries + 9'd1;
	assign pings_inc = (cur.pings == PINGS_SAT) ? cur.pings : cur.pings + 8'd1;

	always_comb begin
		nxt               = cur;
		res.send_ping     = 1'b0;
		res.send_connect  = 1'b0;
		res.close_channel = 1'b0;
		res.dial_channel  = 1'b0;
		res.reset_parser  = 1'b0;
		res.notice        = NOTE_NONE;
		res.error_code    = ERR_NONE;
		case (mode_t'(mode))
			MODE_START: begin
				if (cur.link == LS_CLOSED) begin
					nxt.pings        = '0;
					nxt.tries        = '0;
					nxt.timer_on     = 1'b0;
					res.dial_channel = 1'b1;
					if (connect_ok) begin
						nxt.link         = LS_CONNECTING;
						nxt.chan_open    = 1'b1;
						res.reset_parser = 1'b1;
					end else begin
						nxt.chan_open  = 1'b0;
						res.error_code = ERR_CONNECT_FAILED;
					end
				end
			end
			MODE_INFO: begin
				if (cur.chan_open) begin
					res.send_connect = 1'b1;
					res.send_ping    = 1'b1;
				end
			end
			MODE_PONG: begin
				nxt.pings = '0;
				if (cur.link == LS_CONNECTING) begin
					nxt.link   = LS_CONNECTED;
					res.notice = NOTE_CONNECTED;
				end
			end
			MODE_PING_TICK: begin
				if (cur.link == LS_CONNECTED) begin
					if (cur.pings >= regs.max_pings_out) begin
						res.error_code    = ERR_PING_TIMEOUT;
						res.close_channel = 1'b1;
						nxt.chan_open     = 1'b0;
					end else begin
						res.send_ping = 1'b1;
						nxt.pings     = pings_inc;
					end
				end
			end
			MODE_CLOSED: begin
				if (cur.link != LS_CLOSED) begin
					nxt.link       = LS_DISCONNECTED;
					nxt.chan_open  = 1'b0;
					res.error_code = ERR_CONN_LOST;
					res.notice     = NOTE_DISCONNECTED;
					if (regs.allow_reconnect && (cur.tries < {1'b0, regs.max_reconnect})
							&& !cur.timer_on) begin
						nxt.link     = LS_RECONNECTING;
						nxt.tries    = '0;
						nxt.timer_on = 1'b1;
					end
				end
			end
			MODE_RECONNECT: begin
				if (cur.timer_on) begin
					if (cur.link == LS_CLOSED) begin
						nxt.timer_on = 1'b0;
					end else begin
						nxt.tries = tries_inc;
						if (tries_inc > {1'b0, regs.max_reconnect}) begin
							res.error_code = ERR_RECONNECT_LIM;
							nxt.timer_on   = 1'b0;
						end else begin
							if (cur.chan_open) begin
								res.close_channel = 1'b1;
							end
							nxt.chan_open    = connect_ok;
							res.dial_channel = 1'b1;
							if (connect_ok) begin
								nxt.link         = LS_CONNECTING;
								res.reset_parser = 1'b1;
							end else if (cur.link == LS_CONNECTED) begin
								nxt.timer_on = 1'b0;
							end
						end
					end
				end
			end
			MODE_USER_CLOSE: begin
				if (cur.link != LS_CLOSED) begin
					nxt.link          = LS_CLOSED;
					nxt.timer_on      = 1'b0;
					nxt.chan_open     = 1'b0;
					res.close_channel = cur.chan_open;
				end
			end
			default: ;
		endcase
		res.link_state = nxt.link;
	end
endmodule
